[rtl/int4_group_scaled_dot_product_macros.svh]
// Assertion macros shared by the dot product block.
`ifndef INT4_GROUP_SCALED_DOT_PRODUCT_MACROS_SVH
`define INT4_GROUP_SCALED_DOT_PRODUCT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IGSDP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("igsdp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IGSDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("igsdp: next-cycle check failed");

`endif

[rtl/igsdp_pkg.sv]
// Widths and types shared by the dot product block.
package igsdp_pkg;

  localparam int ACT_W  = 16;               // Q3.12 activation
  localparam int SCL_W  = 16;               // Q3.12 group scale
  localparam int NIB_W  = 4;                // int4 weight
  localparam int PAIR_W = 2 * NIB_W;        // packed weight byte
  localparam int WP_W   = ACT_W + NIB_W;    // act * weight
  localparam int LP_W   = WP_W + SCL_W;     // act * weight * scale
  localparam int SUM_W  = 48;               // accumulator, 24 fraction bits

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

[rtl/igsdp_in_if.sv]
// Column pair channel: valid/ready handshake with the pair payload.
interface igsdp_in_if;
  import igsdp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ACT_W-1:0]  act_even;
  logic signed [ACT_W-1:0]  act_odd;
  logic        [PAIR_W-1:0] packed_pair;
  logic signed [SCL_W-1:0]  group_scale;
  logic                     last_pair;

  modport source (output valid, act_even, act_odd, packed_pair, group_scale, last_pair,
                  input ready);
  modport sink   (input valid, act_even, act_odd, packed_pair, group_scale, last_pair,
                  output ready);
endinterface

[rtl/igsdp_out_if.sv]
// Result channel: valid/ready handshake with the dot product sum.
interface igsdp_out_if;
  import igsdp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] dot_sum;

  modport source (output valid, dot_sum, input ready);
  modport sink   (input valid, dot_sum, output ready);
endinterface

[rtl/igsdp_lane.sv]
// One multiplier lane: activation times int4 weight, then times group scale.
module igsdp_lane
  import igsdp_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ACT_W-1:0] act,
  input  logic        [NIB_W-1:0] nibble,
  input  logic signed [SCL_W-1:0] scale,
  output logic signed [LP_W-1:0]  prod
);

  logic signed [WP_W-1:0]  wprod;
  logic signed [SCL_W-1:0] scale_d;
  logic signed [WP_W-1:0]  wprod_next;
  logic signed [LP_W-1:0]  prod_next;

  // nibble is two's complement, -8..7
  always_comb begin
    wprod_next = WP_W'(act) * WP_W'($signed(nibble));
    prod_next  = LP_W'(wprod) * LP_W'(scale_d);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wprod   <= wprod_next;
      scale_d <= scale;
      prod    <= prod_next;
    end
  end

endmodule

[rtl/igsdp_merge.sv]
// Merge stage: adds the lane products into the running sum, emits on last pair.
module igsdp_merge
  import igsdp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  ctl_t                   ctl,
  input  logic signed [LP_W-1:0] prod_even,
  input  logic signed [LP_W-1:0] prod_odd,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic signed [SUM_W-1:0] out_sum
);

  logic signed [SUM_W-1:0] running_sum;
  logic signed [SUM_W-1:0] running_sum_next;

  // sum wraps modulo 2^48
  always_comb begin
    running_sum_next = running_sum + SUM_W'(prod_even) + SUM_W'(prod_odd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (en && ctl.valid && ctl.last) begin
        running_sum <= '0;
        out_valid   <= 1'b1;
      end else begin
        if (out_valid && out_ready) begin
          out_valid <= 1'b0;
        end
        if (en && ctl.valid) begin
          running_sum <= running_sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && ctl.valid && ctl.last) begin
      out_sum <= running_sum_next;
    end
  end

endmodule

[rtl/int4_group_scaled_dot_product.sv]
// Pipeline: a pair accepted into s1 and the lane wprod registers moves on to s2 and
// the lane prod registers, then updates the sum in the merge stage, which registers a last pair's result.
// Throughput: one column pair per cycle through the two multiplier lanes; the
// pipeline stalls only while a last pair meets an untaken result.
// Reset (rst, synchronous): clears the running sum, stage valids and the result valid.
module int4_group_scaled_dot_product
  import igsdp_pkg::*;
(
  input logic         clk,
  input logic         rst,
  igsdp_in_if.sink    pairs,
  igsdp_out_if.source sums
);

`include "int4_group_scaled_dot_product_macros.svh"

  ctl_t s1;
  ctl_t s2;
  logic en;
  logic signed [LP_W-1:0] prod_even;
  logic signed [LP_W-1:0] prod_odd;

  // hold everything only when a last pair would overwrite an untaken result
  assign en = !(s2.valid && s2.last && sums.valid && !sums.ready);
  assign pairs.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else if (en) begin
      s1.valid <= pairs.valid;
      s1.last  <= pairs.last_pair;
      s2       <= s1;
    end
  end

  igsdp_lane u_lane_even (
    .clk    (clk),
    .en     (en),
    .act    (pairs.act_even),
    .nibble (pairs.packed_pair[NIB_W-1:0]),
    .scale  (pairs.group_scale),
    .prod   (prod_even)
  );

  igsdp_lane u_lane_odd (
    .clk    (clk),
    .en     (en),
    .act    (pairs.act_odd),
    .nibble (pairs.packed_pair[PAIR_W-1:NIB_W]),
    .scale  (pairs.group_scale),
    .prod   (prod_odd)
  );

  igsdp_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ctl       (s2),
    .prod_even (prod_even),
    .prod_odd  (prod_odd),
    .out_ready (sums.ready),
    .out_valid (sums.valid),
    .out_sum   (sums.dot_sum)
  );

  `IGSDP_ASSERT_NOW(a_stall_only_on_full, !pairs.ready, sums.valid && !sums.ready)
  `IGSDP_ASSERT_NEXT(a_last_gives_result, en && s2.valid && s2.last, sums.valid)
  `IGSDP_ASSERT_NEXT(a_no_spurious_result, !sums.valid && !(s2.valid && s2.last), !sums.valid)

endmodule

[test/int4_group_scaled_dot_product_test.sv]
// Self-checking testbench for the int4 group-scaled dot product block.
module int4_group_scaled_dot_product_test;
  import igsdp_pkg::*;

  localparam int HOLD_CYCLES = 120;
  localparam int PHASE_PAIRS = 350;

  typedef struct packed {
    logic signed [ACT_W-1:0]  act_even;
    logic signed [ACT_W-1:0]  act_odd;
    logic        [PAIR_W-1:0] weights;
    logic signed [SCL_W-1:0]  scale;
    logic                     last;
  } column_pair_t;

  class dot_product_scoreboard;
    logic signed [SUM_W-1:0] running_sum;
    logic signed [SUM_W-1:0] expected_sums[$];
    int errors;
    int sums_checked;
    int dot_products;

    function new();
      running_sum = '0;
      errors = 0;
      sums_checked = 0;
      dot_products = 0;
    endfunction

    task report(input string what);
      if (errors < 30) $display("mismatch: %s", what);
      errors++;
    endtask

    // Exact term: Q3.12 act * int4 weight * Q3.12 scale, sum kept modulo 2^48.
    function void note_pair(input column_pair_t p);
      logic signed [NIB_W-1:0] w_even;
      logic signed [NIB_W-1:0] w_odd;
      longint term;
      w_even = p.weights[NIB_W-1:0];
      w_odd  = p.weights[PAIR_W-1:NIB_W];
      term = longint'(p.act_even) * longint'(w_even) * longint'(p.scale)
           + longint'(p.act_odd) * longint'(w_odd) * longint'(p.scale);
      running_sum = running_sum + term[SUM_W-1:0];
      if (p.last) begin
        expected_sums.push_back(running_sum);
        running_sum = '0;
        dot_products++;
      end
    endfunction

    task check_sum(input logic signed [SUM_W-1:0] got);
      logic signed [SUM_W-1:0] want;
      if (expected_sums.size() == 0) begin
        report($sformatf("dot_sum %0d with no dot product pending", got));
      end else begin
        want = expected_sums.pop_front();
        sums_checked++;
        if (got !== want)
          report($sformatf("dot_sum %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  igsdp_in_if  pairs_if ();
  igsdp_out_if sums_if ();

  int4_group_scaled_dot_product dut (
    .clk   (clk),
    .rst   (rst),
    .pairs (pairs_if.sink),
    .sums  (sums_if.source)
  );

  dot_product_scoreboard sb = new();

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int holds_requested = 0;
  int holds_done = 0;
  int hold_left = 0;
  int pairs_sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check on each accepted item, then pick ready for the next edge.
  always @(posedge clk) begin
    if (!rst && sums_if.valid && sums_if.ready) sb.check_sum(sums_if.dot_sum);
    if (holds_requested != holds_done) begin
      hold_left = HOLD_CYCLES;
      holds_done = holds_done + 1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      sums_if.ready <= 1'b0;
    end else begin
      sums_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic logic [15:0] rand_q12();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic column_pair_t mk_pair(input logic [15:0] ae, input logic [15:0] ao,
                                           input logic [7:0] pk, input logic [15:0] sc,
                                           input logic lst);
    column_pair_t p;
    p.act_even = ae;
    p.act_odd  = ao;
    p.weights  = pk;
    p.scale    = sc;
    p.last     = lst;
    return p;
  endfunction

  task send_pair(input column_pair_t p);
    pairs_if.valid       <= 1'b1;
    pairs_if.act_even    <= p.act_even;
    pairs_if.act_odd     <= p.act_odd;
    pairs_if.packed_pair <= p.weights;
    pairs_if.group_scale <= p.scale;
    pairs_if.last_pair   <= p.last;
    @(posedge clk);
    while (!pairs_if.ready) @(posedge clk);
    sb.note_pair(p);
    pairs_sent++;
    if ($urandom_range(99) < src_idle_pct) begin
      pairs_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  task send_run(input int len);
    column_pair_t p;
    for (int i = 0; i < len; i++) begin
      p = mk_pair(rand_q12(), rand_q12(), 8'($urandom), rand_q12(), i == len - 1);
      send_pair(p);
    end
  endtask

  task random_phase(input int src_pct, input int rx_pct, input int count);
    int target;
    int pick;
    target = pairs_sent + count;
    src_idle_pct = src_pct;
    sink_idle_pct <= rx_pct;
    while (pairs_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 80)      send_run($urandom_range(1, 6));
      else if (pick < 96) send_run($urandom_range(7, 40));
      else                send_run($urandom_range(41, 200));
    end
  endtask

  initial begin
    rst = 1'b1;
    pairs_if.valid = 1'b0;
    pairs_if.act_even = '0;
    pairs_if.act_odd = '0;
    pairs_if.packed_pair = '0;
    pairs_if.group_scale = '0;
    pairs_if.last_pair = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, single-pair and multi-pair dot products.
    src_idle_pct = 12;
    sink_idle_pct <= 75;
    send_pair(mk_pair(16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1));
    send_pair(mk_pair(16'h8000, 16'h8000, 8'h88, 16'h8000, 1'b1));
    send_pair(mk_pair(16'h8000, 16'h8000, 8'h88, 16'h7fff, 1'b1));
    send_pair(mk_pair(16'h7fff, 16'h7fff, 8'h77, 16'h7fff, 1'b1));
    send_pair(mk_pair(16'h7fff, 16'h8000, 8'h87, 16'h8000, 1'b1));
    send_pair(mk_pair(16'h8000, 16'h7fff, 8'h78, 16'h7fff, 1'b1));
    send_pair(mk_pair(16'hffff, 16'h0001, 8'hf1, 16'h1000, 1'b1));
    send_pair(mk_pair(16'h1000, 16'h1000, 8'h0f, 16'h1000, 1'b0));
    send_pair(mk_pair(16'h1000, 16'hf000, 8'hf0, 16'hffff, 1'b0));
    send_pair(mk_pair(16'h7fff, 16'h8000, 8'h80, 16'h0001, 1'b0));
    send_pair(mk_pair(16'h8000, 16'h7fff, 8'h08, 16'h8000, 1'b1));
    send_pair(mk_pair(16'h5555, 16'haaaa, 8'h7f, 16'haaaa, 1'b0));
    send_pair(mk_pair(16'haaaa, 16'h5555, 8'hff, 16'h5555, 1'b1));
    send_pair(mk_pair(16'h0001, 16'hffff, 8'h11, 16'h0001, 1'b1));

    random_phase(12, 75, PHASE_PAIRS);
    random_phase(75, 12, PHASE_PAIRS);

    // Result side holds off while one-pair dot products keep coming.
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    holds_requested <= holds_requested + 1;
    repeat (60) send_run(1);

    random_phase(0, 0, PHASE_PAIRS);

    pairs_if.valid <= 1'b0;
    while (sb.expected_sums.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d column pairs in %0d dot products, %0d sums checked;",
             pairs_sent, sb.dot_products, sb.sums_checked);
    $display("covered field extremes, runs of 1 to 200 pairs and a %0d-cycle result stall",
             HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("timeout with %0d sums outstanding", sb.expected_sums.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
